/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the window stack RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wsht_pkg.sv */
// Shared types and constants for the window stack hit test block.
// No dependencies.
package wsht_pkg;

  localparam int unsigned FIELD_BITS = 12;
  localparam int unsigned NUM_BITS   = 5;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_CLICK = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] rect_left;
    logic [FIELD_BITS-1:0] rect_bottom;
    logic [FIELD_BITS-1:0] rect_right;
    logic [FIELD_BITS-1:0] rect_top;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic                hit;
    logic [NUM_BITS-1:0] window_number;
  } out_t;

endpackage

/* hw/rtl/wsht_mem.sv */
// Window stack store: one write port, one read port with registered data.
// Standalone; widths come from the instantiating module.
module wsht_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned W     = 53
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/wsht_hit.sv */
// Inclusive rectangle containment test, shared across all stack entries.
// Standalone; coordinate width comes from the instantiating module.
module wsht_hit #(
  parameter int unsigned CB = 12
) (
  input  logic [CB-1:0] left_i,
  input  logic [CB-1:0] bottom_i,
  input  logic [CB-1:0] right_i,
  input  logic [CB-1:0] top_i,
  input  logic [CB-1:0] x_i,
  input  logic [CB-1:0] y_i,
  output logic          contains_o
);

  // An inverted rectangle fails one of the pairs and so never matches.
  assign contains_o = (x_i >= left_i) && (x_i <= right_i) &&
                      (y_i >= bottom_i) && (y_i <= top_i);

endmodule

/* hw/rtl/window_stack_hit_test_top.sv */
// Window stack hit test: top level with the search and reorder sequencer.
// Depends on wsht_pkg, wsht_mem, wsht_hit and assert_macros.svh.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) takes one
//   transaction per item. A load (kind = 0) appends a rectangle on top of
//   the stack in the cycle it is accepted and gives no result; loads into a
//   full stack are dropped. A click (kind = 1) gives exactly one result on
//   the output channel (out_valid_o / out_stall_i / out_data_o).
//   A click walks the stack from the top through one read port and one
//   compare unit, one entry a cycle, and then moves the hit entry to the
//   top, one entry a cycle through the same port.
//   in_stall_o is high while a click is in progress.
//   The result sits in an output register; a stalled receiver holds it, and
//   a following load may still be taken meanwhile. A click result waits
//   until that register is free.
//   Reset empties the stack (window count zero); the store itself needs no
//   clearing since only entries below the count are read.
`include "assert_macros.svh"

module window_stack_hit_test_top #(
  parameter int unsigned MAX_WINDOWS = 16,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wsht_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wsht_pkg::out_t   out_data_o
);

  localparam int unsigned AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned NW = CW;
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = 4 * CB + NW;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WINDOWS);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CB-1:0] x_q, x_d, y_q, y_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          issue_q, issue_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] sh_q, sh_d;
  logic [EW-1:0] picked_q, picked_d;
  logic          res_hit_q, res_hit_d;
  logic [NW-1:0] res_num_q, res_num_d;
  logic          out_vld_q, out_vld_d;
  wsht_pkg::out_t out_q;

  logic          in_acc;
  logic          res_load;
  logic [CW-1:0] cnt_m1;

  // Store port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] rd_data;

  logic          in_rect;
  logic [NW-1:0] rd_num;

  // Coordinates are taken modulo 2^COORD_BITS
  logic [31:0] l32, b32, r32, t32, px32, py32, num32;
  logic [EW-1:0] load_entry;

  assign l32  = 32'(in_data_i.rect_left);
  assign b32  = 32'(in_data_i.rect_bottom);
  assign r32  = 32'(in_data_i.rect_right);
  assign t32  = 32'(in_data_i.rect_top);
  assign px32 = 32'(in_data_i.point_x);
  assign py32 = 32'(in_data_i.point_y);

  assign cnt_m1     = cnt_q - CW'(1);
  assign load_entry = {NW'(cnt_q + CW'(1)), t32[CB-1:0], r32[CB-1:0],
                       b32[CB-1:0], l32[CB-1:0]};
  assign rd_num     = rd_data[EW-1:4*CB];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  wsht_mem #(
    .DEPTH (MAX_WINDOWS),
    .AW    (AW),
    .W     (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  wsht_hit #(
    .CB (CB)
  ) u_hit (
    .left_i     (rd_data[CB-1:0]),
    .bottom_i   (rd_data[2*CB-1:CB]),
    .right_i    (rd_data[3*CB-1:2*CB]),
    .top_i      (rd_data[4*CB-1:3*CB]),
    .x_i        (x_q),
    .y_i        (y_q),
    .contains_o (in_rect)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    idx_d     = idx_q;
    issue_d   = issue_q;
    rd_vld_d  = rd_vld_q;
    rd_idx_d  = rd_idx_q;
    sh_d      = sh_q;
    picked_d  = picked_q;
    res_hit_d = res_hit_q;
    res_num_d = res_num_q;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = picked_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.kind == wsht_pkg::KIND_LOAD) begin
            // Append on top; drop when full
            if (cnt_q < MAX_CNT) begin
              mem_we    = 1'b1;
              mem_waddr = cnt_q[AW-1:0];
              mem_wdata = load_entry;
              cnt_d     = cnt_q + CW'(1);
            end
          end else begin
            x_d      = px32[CB-1:0];
            y_d      = py32[CB-1:0];
            rd_vld_d = 1'b0;
            if (cnt_q == '0) begin
              res_hit_d = 1'b0;
              res_num_d = '0;
              state_d   = S_OUT;
            end else begin
              idx_d   = cnt_m1[AW-1:0];
              issue_d = 1'b1;
              state_d = S_SEARCH;
            end
          end
        end
      end

      S_SEARCH: begin
        // Read one entry ahead while comparing the one read last cycle
        mem_re    = issue_q;
        mem_raddr = idx_q;
        rd_vld_d  = issue_q;
        rd_idx_d  = idx_q;
        if (issue_q) begin
          if (idx_q == '0) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q - AW'(1);
          end
        end
        if (rd_vld_q) begin
          if (in_rect) begin
            picked_d  = rd_data;
            res_hit_d = 1'b1;
            res_num_d = rd_num;
            sh_d      = CW'(rd_idx_q) + CW'(1);
            rd_vld_d  = 1'b0;
            issue_d   = 1'b0;
            state_d   = S_SHIFT;
          end else if (rd_idx_q == '0) begin
            res_hit_d = 1'b0;
            res_num_d = '0;
            rd_vld_d  = 1'b0;
            state_d   = S_OUT;
          end
        end
      end

      S_SHIFT: begin
        // Move each entry above the hit down one place, then put it on top
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_q - AW'(1);
          mem_wdata = rd_data;
        end
        if (sh_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = sh_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = sh_q[AW-1:0];
          sh_d      = sh_q + CW'(1);
        end else begin
          rd_vld_d = 1'b0;
          if (!rd_vld_q) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m1[AW-1:0];
            mem_wdata = picked_q;
            state_d   = S_OUT;
          end
        end
      end

      S_OUT: begin
        // Hand over once the output register is free
        if (!out_vld_q || !out_stall_i) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_vld_d = res_load || (out_vld_q && out_stall_i);
  assign num32     = 32'(res_num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      issue_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    idx_q     <= idx_d;
    rd_idx_q  <= rd_idx_d;
    sh_q      <= sh_d;
    picked_q  <= picked_d;
    res_hit_q <= res_hit_d;
    res_num_q <= res_num_d;
    if (res_load) begin
      out_q.hit           <= res_hit_q;
      out_q.window_number <= num32[wsht_pkg::NUM_BITS-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `ASSERT_HOLDS(a_cnt_range, cnt_q <= MAX_CNT, "window count beyond capacity")
  `ASSERT_NEXT(a_load_grows,
    in_acc && (in_data_i.kind == wsht_pkg::KIND_LOAD) && (cnt_q < MAX_CNT),
    cnt_q == $past(cnt_q) + CW'(1), "accepted load did not grow the stack")
  `ASSERT_NEXT(a_search_stable, state_q == S_SEARCH, $stable(cnt_q),
    "window count changed during a search")

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for window_stack_hit_test_top: queued loads and clicks, a clocked
// driver and monitor, and a behavioural copy of the window stack that predicts each click.
// Depends on wsht_pkg and the RTL of window_stack_hit_test_top.
module tb;

  localparam int unsigned MAX_WIN        = 16;
  localparam int unsigned COORD_W        = 12;
  localparam int unsigned RANDOM_ITEMS   = 550;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 2 * MAX_WIN + 20;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
  } rect_t;

  typedef struct packed {
    rect_t                         area;
    logic [wsht_pkg::NUM_BITS-1:0] number;
  } window_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic           in_valid  = 1'b0;
  logic           in_stall;
  wsht_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  wsht_pkg::out_t out_data;

  // Transactions waiting to be offered, and results the stack model says must come back.
  wsht_pkg::in_t  pending_items[$];
  wsht_pkg::out_t expected_picks[$];

  // Behavioural window stack: slot 0 is the bottom, slot win_count-1 the top.
  window_t     win_stack[MAX_WIN];
  int unsigned win_count = 0;

  // Rectangles by window number, known when the stimulus is built.
  rect_t       gen_rect[1:MAX_WIN];
  int unsigned gen_loaded = 0;

  int unsigned failures = 0;
  int unsigned n_loads = 0, n_dropped = 0, n_clicks = 0, n_hits = 0, n_misses = 0;
  int unsigned deepest_hit = 0;
  int unsigned idle_cycles = 0;

  // Driver and monitor pacing.
  int unsigned in_gap = 0, in_calm = 0;
  int unsigned out_hold = 0, out_calm = 0;

  window_stack_hit_test_top #(
    .MAX_WINDOWS(MAX_WIN),
    .COORD_BITS (COORD_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic wsht_pkg::in_t make_load(rect_t r);
    wsht_pkg::in_t item;
    item             = wsht_pkg::in_t'({$urandom, $urandom, $urandom});
    item.kind        = wsht_pkg::KIND_LOAD;
    item.rect_left   = r.left;
    item.rect_bottom = r.bottom;
    item.rect_right  = r.right;
    item.rect_top    = r.top;
    return item;
  endfunction

  function automatic wsht_pkg::in_t make_click(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    wsht_pkg::in_t item;
    item         = wsht_pkg::in_t'({$urandom, $urandom, $urandom});
    item.kind    = wsht_pkg::KIND_CLICK;
    item.point_x = x;
    item.point_y = y;
    return item;
  endfunction

  // Queue one transaction for the driver.
  task automatic add_item(wsht_pkg::in_t item);
    pending_items = {pending_items, item};
  endtask

  function automatic rect_t random_rect();
    rect_t       r;
    int unsigned mode, w, h, a, b;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      // Small or medium rectangles, placed anywhere including against the edges.
      w = (mode < 40) ? $urandom_range(0, 63) : $urandom_range(64, 1023);
      h = (mode < 40) ? $urandom_range(0, 63) : $urandom_range(64, 1023);
      r.left   = COORD_W'($urandom_range(0, 4095 - w));
      r.bottom = COORD_W'($urandom_range(0, 4095 - h));
      r.right  = COORD_W'(r.left + w);
      r.top    = COORD_W'(r.bottom + h);
    end else if (mode < 85) begin
      a = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
      r.left  = COORD_W'((a < b) ? a : b);
      r.right = COORD_W'((a < b) ? b : a);
      a = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
      r.bottom = COORD_W'((a < b) ? a : b);
      r.top    = COORD_W'((a < b) ? b : a);
    end else begin
      // Inverted on one axis: such a window can never be hit.
      r = rect_t'({$urandom, $urandom});
      a = $urandom_range(1, 4095);
      b = $urandom_range(0, a - 1);
      if ($urandom_range(0, 1)) begin
        r.left  = COORD_W'(a);
        r.right = COORD_W'(b);
      end else begin
        r.bottom = COORD_W'(a);
        r.top    = COORD_W'(b);
      end
    end
    return r;
  endfunction

  // Pick a click point: mostly inside a loaded window, else extremes or anywhere.
  function automatic wsht_pkg::in_t random_click();
    int unsigned r, n;
    rect_t       rc;
    logic [COORD_W-1:0] x, y;
    r = $urandom_range(0, 99);
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    if (r < 70 && gen_loaded != 0) begin
      n  = $urandom_range(1, gen_loaded);
      rc = gen_rect[n];
      if (rc.left <= rc.right && rc.bottom <= rc.top) begin
        x = COORD_W'($urandom_range(rc.left, rc.right));
        y = COORD_W'($urandom_range(rc.bottom, rc.top));
        // Land on the boundary every so often.
        if ($urandom_range(0, 3) == 0) x = $urandom_range(0, 1) ? rc.right : rc.left;
        if ($urandom_range(0, 3) == 0) y = $urandom_range(0, 1) ? rc.top : rc.bottom;
      end
    end else if (r < 82) begin
      x = $urandom_range(0, 1) ? COORD_MAX : '0;
      y = $urandom_range(0, 1) ? COORD_MAX : '0;
    end
    return make_click(x, y);
  endfunction

  function automatic bit point_in(rect_t r, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    return x >= r.left && x <= r.right && y >= r.bottom && y <= r.top;
  endfunction

  // Apply one accepted transaction to the stack model; a click queues its expected result.
  task automatic track_window_stack(wsht_pkg::in_t item);
    wsht_pkg::out_t res;
    window_t        picked;
    int             found;
    int             i;
    if (item.kind == wsht_pkg::KIND_LOAD) begin
      if (win_count < MAX_WIN) begin
        win_stack[win_count].area   = '{item.rect_left, item.rect_bottom,
                                        item.rect_right, item.rect_top};
        win_stack[win_count].number = wsht_pkg::NUM_BITS'(win_count + 1);
        win_count++;
        n_loads++;
      end else begin
        n_dropped++;
      end
    end else begin
      n_clicks++;
      found = -1;
      for (i = int'(win_count) - 1; i >= 0 && found < 0; i--) begin
        if (point_in(win_stack[i].area, item.point_x, item.point_y)) found = i;
      end
      res = '0;
      if (found >= 0) begin
        // Move the hit window to the top; those above it sink one place.
        picked = win_stack[found];
        for (i = found; i + 1 < int'(win_count); i++) win_stack[i] = win_stack[i + 1];
        win_stack[win_count - 1] = picked;
        res.hit           = 1'b1;
        res.window_number = picked.number;
        n_hits++;
        if (win_count - 1 - found > deepest_hit) deepest_hit = win_count - 1 - found;
      end else begin
        n_misses++;
      end
      expected_picks = {expected_picks, res};
    end
  endtask

  task automatic report_failure(string what, wsht_pkg::out_t want, wsht_pkg::out_t got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%0t: %s: expected hit=%0d number=%0d, got hit=%0d number=%0d", $realtime,
               what, want.hit, want.window_number, got.hit, got.window_number);
  endtask

  // Driver: hold a stalled transaction, advance to the next one after acceptance or a gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) track_window_stack(in_data);
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          if (in_calm != 0) begin
            in_calm--;
          end else if ($urandom_range(0, 49) == 0) begin
            in_calm = $urandom_range(20, 60);
          end else begin
            in_gap = random_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    wsht_pkg::out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_picks.size() == 0) begin
          report_failure("result with no click pending", '0, out_data);
        end else begin
          want = expected_picks.pop_front();
          if (out_data.hit !== want.hit || out_data.window_number !== want.window_number)
            report_failure("result mismatch", want, out_data);
        end
      end
      if (out_hold != 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
        if (out_calm != 0) out_calm--;
        else if ($urandom_range(0, 59) == 0) out_calm = $urandom_range(20, 80);
        else if ($urandom_range(0, 3) == 0) out_hold = random_gap();
      end
    end
  end

  // Watchdog: give up when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_picks.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned counted;
    bit          do_load;
    rect_t       r;

    // Directed: empty stack, full-screen window, inverted windows, single-pixel windows,
    // edges of a small window, corner of the plane.
    add_item(make_click('0, '0));
    add_item(make_click(COORD_MAX, COORD_MAX));
    add_item(make_load('{'0, '0, COORD_MAX, COORD_MAX}));
    add_item(make_click('0, '0));
    add_item(make_click(COORD_MAX, COORD_MAX));
    add_item(make_click('0, COORD_MAX));
    add_item(make_load('{12'd100, 12'd0, 12'd50, COORD_MAX}));
    add_item(make_click(12'd75, 12'd10));
    add_item(make_load('{12'd0, COORD_MAX, COORD_MAX, 12'd0}));
    add_item(make_click(12'd2000, 12'd2000));
    add_item(make_load('{12'd2048, 12'd2048, 12'd2048, 12'd2048}));
    add_item(make_click(12'd2048, 12'd2048));
    add_item(make_click(12'd2047, 12'd2048));
    add_item(make_click(12'd2049, 12'd2048));
    add_item(make_load('{12'd10, 12'd20, 12'd30, 12'd40}));
    add_item(make_click(12'd10, 12'd20));
    add_item(make_click(12'd30, 12'd40));
    add_item(make_click(12'd31, 12'd40));
    add_item(make_click(12'd30, 12'd41));
    add_item(make_load('{'0, '0, '0, '0}));
    add_item(make_click('0, '0));
    add_item(make_click(12'd2048, 12'd2048));
    gen_rect[1] = '{'0, '0, COORD_MAX, COORD_MAX};
    gen_rect[2] = '{12'd100, 12'd0, 12'd50, COORD_MAX};
    gen_rect[3] = '{12'd0, COORD_MAX, COORD_MAX, 12'd0};
    gen_rect[4] = '{12'd2048, 12'd2048, 12'd2048, 12'd2048};
    gen_rect[5] = '{12'd10, 12'd20, 12'd30, 12'd40};
    gen_rect[6] = '{'0, '0, '0, '0};
    gen_loaded  = 6;

    // Random: fill the stack interleaved with clicks, then mostly clicks on a full stack
    // with the odd load that must be dropped.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      do_load = (gen_loaded < MAX_WIN) ? ($urandom_range(0, 5) == 0)
                                       : ($urandom_range(0, 24) == 0);
      if (do_load) begin
        r = random_rect();
        add_item(make_load(r));
        if (gen_loaded < MAX_WIN) begin
          gen_loaded++;
          gen_rect[gen_loaded] = r;
          counted++;
        end
      end else begin
        add_item(random_click());
        counted++;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_picks.size() != 0) @(posedge clk_i);
    // Let a late load settle and give a stray result the chance to show up.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d loads (%0d dropped on a full stack) and %0d clicks",
             n_loads, n_dropped, n_clicks);
    $display("clicks: %0d hits, %0d misses, deepest hit %0d below the top; %0d failures",
             n_hits, n_misses, deepest_hit, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/wsht_pkg.sv
hw/rtl/wsht_mem.sv
hw/rtl/wsht_hit.sv
hw/rtl/window_stack_hit_test_top.sv
bench/tb.sv
